/* sv/asep_pkg.sv */
package asep_pkg;

  localparam int unsigned PcmW = 16;
  localparam int unsigned StepW = 15;
  localparam int unsigned StepLen = 89;
  localparam int unsigned StepPosW = 7;

  typedef logic signed [PcmW-1:0] pcm_t;
  typedef logic [StepW-1:0] step_t;

  localparam pcm_t PcmMax = 16'sh7FFF;
  localparam pcm_t PcmMin = 16'sh8000;

  typedef enum logic [1:0] {
    PackOne    = 2'd0,
    PackNibble = 2'd1,
    PackCrumb  = 2'd2,
    PackRsvd   = 2'd3
  } pack_mode_e;

  typedef struct packed {
    logic       neg;
    logic [2:0] mag;
  } asep_code_t;

  localparam step_t StepTable [StepLen] = '{
    15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
    15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
    15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
    15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
    15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
    15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
    15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
    15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
    15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
    15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
    15'd27086, 15'd29794, 15'd32767
  };

  // positions past the table read its last entry
  function automatic step_t step_of(logic [StepPosW-1:0] pos);
    step_t res;
    if (pos >= StepPosW'(StepLen - 1)) begin
      res = StepTable[StepLen-1];
    end else begin
      res = StepTable[pos];
    end
    return res;
  endfunction

endpackage

/* sv/asep_quant.sv */
module asep_quant (
  input  asep_pkg::pcm_t       sample_i,
  input  asep_pkg::pcm_t       pred_i,
  input  asep_pkg::step_t      step_i,
  output asep_pkg::asep_code_t code_o,
  output asep_pkg::pcm_t       pred_next_o
);
  import asep_pkg::*;

  logic signed [PcmW:0]   diff;
  logic [PcmW:0]          diff_abs;
  logic                   neg;
  logic [PcmW+1:0]        mult [8];
  logic [2:0]             mag;
  logic [PcmW+1:0]        q;
  logic signed [PcmW+3:0] pred_ext;
  logic signed [PcmW+3:0] q_ext;
  logic signed [PcmW+3:0] sum;

  assign diff     = (PcmW+1)'(sample_i) - (PcmW+1)'(pred_i);
  assign neg      = diff[PcmW];
  assign diff_abs = neg ? (PcmW+1)'(-diff) : (PcmW+1)'(diff);

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      mult[k] = (PcmW+2)'(step_i) * (PcmW+2)'(k);
    end
  end

  always_comb begin
    mag = '0;
    for (int k = 1; k < 8; k++) begin
      if ({1'b0, diff_abs} >= mult[k]) begin
        mag = 3'(k);
      end
    end
  end

  assign q        = mult[mag] + (PcmW+2)'(step_i >> 1);
  assign pred_ext = (PcmW+4)'(pred_i);
  assign q_ext    = signed'({2'b00, q});
  assign sum      = neg ? pred_ext - q_ext : pred_ext + q_ext;

  always_comb begin
    priority if (sum > (PcmW+4)'(PcmMax)) begin
      pred_next_o = PcmMax;
    end else if (sum < (PcmW+4)'(PcmMin)) begin
      pred_next_o = PcmMin;
    end else begin
      pred_next_o = sum[PcmW-1:0];
    end
  end

  assign code_o = '{neg: neg, mag: mag};

endmodule

/* sv/adpcm_sample_encoder_packer.sv */
// ADPCM encoder with byte packer. Each accepted 16-bit sample is quantized combinationally against
// the running prediction to a sign bit and a 0..7 magnitude, and the prediction and step position
// are registered at that same transfer, so a new sample is taken on every clock while the output
// side is not stalled; a result byte appears in the cycle after the transfer that completes it and
// waits in the output register. pack_mode selects one code per byte, two nibbles per byte (first
// code high), or four two-bit magnitudes per byte (first code in bits 7:6); last_sample flushes a
// partial byte zero-filled. In mode 3 samples are taken and dropped with no state change.
// Write pack_mode only while the block is idle.
module adpcm_sample_encoder_packer #(
  parameter int unsigned STEP_TABLE_ENTRIES = 89
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  asep_pkg::pcm_t pcm_sample_i,
  input  logic           last_sample_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     packed_byte_o,
  output logic           last_byte_o
);
  import asep_pkg::*;

  localparam int unsigned PosW = $clog2(STEP_TABLE_ENTRIES);
  localparam logic [PosW:0] PosMax = (PosW+1)'(STEP_TABLE_ENTRIES - 1);

  pack_mode_e       mode_q;
  pcm_t             pred_q, pred_d;
  logic [PosW-1:0]  pos_q, pos_d;
  step_t            step_q;
  logic [7:0]       acc_q, acc_d;
  logic [1:0]       slot_q, slot_d;
  logic             out_valid_q;
  logic [7:0]       byte_q, byte_d;
  logic             last_q;
  logic             accept, active, emit;
  asep_code_t       code;
  logic [PosW:0]    pos_sum;
  logic [3:0]       move;
  logic [7:0]       crumb_acc;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign active     = accept && (mode_q != PackRsvd);

  asep_quant u_quant (
    .sample_i    (pcm_sample_i),
    .pred_i      (pred_q),
    .step_i      (step_q),
    .code_o      (code),
    .pred_next_o (pred_d)
  );

  assign move    = {1'b0, ({1'b0, code.mag[1:0]} + 3'd1)} << 1;
  assign pos_sum = {1'b0, pos_q} + (PosW+1)'(move);

  always_comb begin
    if (!code.mag[2]) begin
      pos_d = (pos_q == '0) ? '0 : pos_q - PosW'(1);
    end else if (pos_sum > PosMax) begin
      pos_d = PosMax[PosW-1:0];
    end else begin
      pos_d = pos_sum[PosW-1:0];
    end
  end

  assign crumb_acc = acc_q | ({6'b0, code.mag[1:0]} << (3'd6 - {slot_q, 1'b0}));

  always_comb begin
    acc_d  = acc_q;
    slot_d = slot_q;
    byte_d = '0;
    emit   = 1'b0;
    unique case (mode_q)
      PackOne: begin
        byte_d = {4'b0, code};
        emit   = 1'b1;
        acc_d  = '0;
        slot_d = '0;
      end
      PackNibble: begin
        if (slot_q == '0) begin
          if (last_sample_i) begin
            byte_d = {code, 4'b0};
            emit   = 1'b1;
            acc_d  = '0;
            slot_d = '0;
          end else begin
            acc_d  = {code, 4'b0};
            slot_d = 2'd1;
          end
        end else begin
          byte_d = {acc_q[7:4], code};
          emit   = 1'b1;
          acc_d  = '0;
          slot_d = '0;
        end
      end
      PackCrumb: begin
        if (slot_q == 2'd3 || last_sample_i) begin
          byte_d = crumb_acc;
          emit   = 1'b1;
          acc_d  = '0;
          slot_d = '0;
        end else begin
          acc_d  = crumb_acc;
          slot_d = slot_q + 2'd1;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= PackNibble;
    end else if (cfg_we_i) begin
      mode_q <= pack_mode_e'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_q <= '0;
      pos_q  <= '0;
      step_q <= step_of('0);
      acc_q  <= '0;
      slot_q <= '0;
    end else if (active) begin
      pred_q <= pred_d;
      pos_q  <= pos_d;
      step_q <= step_of(StepPosW'(pos_d));
      acc_q  <= acc_d;
      slot_q <= slot_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= active && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((!out_valid_q || !out_stall_i) && active && emit) begin
      byte_q <= byte_d;
      last_q <= last_sample_i;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign packed_byte_o = byte_q;
  assign last_byte_o   = last_q;

endmodule

/* sv/asep_checker.sv */
module asep_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input asep_pkg::pcm_t pcm_sample_i,
  input logic           last_sample_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input logic [7:0]     packed_byte_o,
  input logic           last_byte_o
);

  a_stall_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output register can move");

  a_result_needs_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("result appeared without an input transfer");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(packed_byte_o) && $stable(last_byte_o)))
    else $error("stalled result changed");

  a_no_drop_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> !$past(out_stall_i))
    else $error("result dropped while stalled");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=>
      (in_valid_i && $stable(pcm_sample_i) && $stable(last_sample_i)))
    else $error("stalled input transfer changed");

endmodule

bind adpcm_sample_encoder_packer asep_checker u_asep_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .pcm_sample_i  (pcm_sample_i),
  .last_sample_i (last_sample_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .packed_byte_o (packed_byte_o),
  .last_byte_o   (last_byte_o)
);
